// ===== design/dll_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the doubly linked list block.
// No dependencies; imported by dll_ctrl, dll_dp and doubly_linked_list_with_cursor.
package dll_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int ADDR_W     = $clog2(POOL_DEPTH);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 7;
  localparam int REQ_W      = 4;

  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_DEPTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_QUERY      = 4'd0,
    REQ_CLEAR      = 4'd1,
    REQ_INS_FIRST  = 4'd2,
    REQ_INS_LAST   = 4'd3,
    REQ_GO_FIRST   = 4'd4,
    REQ_GO_LAST    = 4'd5,
    REQ_DEL_FIRST  = 4'd6,
    REQ_DEL_LAST   = 4'd7,
    REQ_DEL_AFTER  = 4'd8,
    REQ_DEL_BEFORE = 4'd9,
    REQ_INS_AFTER  = 4'd10,
    REQ_INS_BEFORE = 4'd11,
    REQ_SET_VALUE  = 4'd12,
    REQ_PREVIOUS   = 4'd13,
    REQ_NEXT       = 4'd14
  } req_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic                     status;
    logic                     list_empty;
    logic                     active_valid;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] last_value;
    logic signed [DATA_W-1:0] active_value;
    logic [CNT_W-1:0]         element_count;
  } rsp_item_t;

  // Sequencer to datapath commands, one step of a request each
  typedef struct packed {
    logic load;
    logic rd2;
    logic calc;
    logic wr1;
    logic wr2;
    logic rd_tail;
    logic rd_cur;
    logic cap_head;
    logic cap_tail;
    logic cap_cur;
  } dp_cmd_t;

endpackage

// ===== design/dll_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/dll_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer: steps each request through link reads, update, link
// writes and value reads. Depends on dll_pkg.
module dll_ctrl
  import dll_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_CALC, S_WR1, S_WR2,
    S_RDH, S_RDT, S_RDC, S_CAPC, S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (req_valid) state <= S_RD1;
        S_RD1:   state <= S_RD2;
        S_RD2:   state <= S_CALC;
        S_CALC:  state <= S_WR1;
        S_WR1:   state <= S_WR2;
        S_WR2:   state <= S_RDH;
        S_RDH:   state <= S_RDT;
        S_RDT:   state <= S_RDC;
        S_RDC:   state <= S_CAPC;
        S_CAPC:  state <= S_DONE;
        S_DONE:  if (rsp_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && req_valid;
    cmd.rd2      = (state == S_RD2);
    cmd.calc     = (state == S_CALC);
    cmd.wr1      = (state == S_WR1);
    cmd.wr2      = (state == S_WR2);
    cmd.rd_tail  = (state == S_RDT);
    cmd.rd_cur   = (state == S_RDC);
    cmd.cap_head = (state == S_RDT);
    cmd.cap_tail = (state == S_RDC);
    cmd.cap_cur  = (state == S_CAPC);
  end

endmodule

// ===== design/dll_dp.sv =====
`timescale 1ns / 1ps
// Datapath: list pointers, node pool memories and the result register.
// Depends on dll_pkg and dll_ram.
module dll_dp
  import dll_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  req_item_t req,
  output rsp_item_t rsp
);

  typedef logic [IDX_W-1:0] idx_t;

  req_t                req_q;
  logic [DATA_W-1:0]   val_q;
  idx_t                head, tail, cur, free_head, fresh, live_count;
  idx_t                head_next, tail_next, cur_next, free_next, fresh_next, count_next;
  idx_t                r1n, r1p;
  logic                status_next;

  // Pending link and data writes, two slots
  logic                w1n_en, w1p_en, w2n_en, w2p_en, wd_en;
  idx_t                w1n_addr, w1p_addr, w2n_addr, w2p_addr, wd_addr;
  idx_t                w1n_data, w1p_data, w2n_data, w2p_data;
  logic                w1n_en_next, w1p_en_next, w2n_en_next, w2p_en_next, wd_en_next;
  idx_t                w1n_addr_next, w1p_addr_next, w2n_addr_next, w2p_addr_next;
  idx_t                wd_addr_next;
  idx_t                w1n_data_next, w1p_data_next, w2n_data_next, w2p_data_next;

  idx_t                addr1, addr2, rd_idx, data_ridx;
  idx_t                next_rdata, prev_rdata;
  logic [DATA_W-1:0]   data_rdata;
  logic                nram_we, pram_we;
  idx_t                nram_waddr, pram_waddr, nram_wdata, pram_wdata;

  function automatic logic is_node(input idx_t i);
    return i < NULL_IDX;
  endfunction

  // Link reads: first at the anchor node, second at the node it names or free_head.
  // The first read's data is on the RAM outputs while the second address is issued.
  always_comb begin
    unique case (req_q)
      REQ_DEL_FIRST:               addr1 = head;
      REQ_DEL_LAST:                addr1 = tail;
      REQ_INS_FIRST, REQ_INS_LAST: addr1 = free_head;
      default:                     addr1 = cur;
    endcase
    unique case (req_q)
      REQ_DEL_AFTER:  addr2 = next_rdata;
      REQ_DEL_BEFORE: addr2 = prev_rdata;
      default:        addr2 = free_head;
    endcase
    rd_idx = cmd.rd2 ? addr2 : addr1;
    data_ridx = cmd.rd_tail ? tail : (cmd.rd_cur ? cur : head);
  end

  assign nram_we    = (cmd.wr1 && w1n_en) || (cmd.wr2 && w2n_en);
  assign nram_waddr = cmd.wr2 ? w2n_addr : w1n_addr;
  assign nram_wdata = cmd.wr2 ? w2n_data : w1n_data;
  assign pram_we    = (cmd.wr1 && w1p_en) || (cmd.wr2 && w2p_en);
  assign pram_waddr = cmd.wr2 ? w2p_addr : w1p_addr;
  assign pram_wdata = cmd.wr2 ? w2p_data : w1p_data;

  dll_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk(clk), .we(nram_we), .waddr(nram_waddr[ADDR_W-1:0]), .wdata(nram_wdata),
    .raddr(rd_idx[ADDR_W-1:0]), .rdata(next_rdata)
  );

  dll_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk(clk), .we(pram_we), .waddr(pram_waddr[ADDR_W-1:0]), .wdata(pram_wdata),
    .raddr(rd_idx[ADDR_W-1:0]), .rdata(prev_rdata)
  );

  dll_ram #(.WIDTH(DATA_W), .DEPTH(POOL_DEPTH)) u_data_ram (
    .clk(clk), .we(cmd.wr1 && wd_en), .waddr(wd_addr[ADDR_W-1:0]), .wdata(val_q),
    .raddr(data_ridx[ADDR_W-1:0]), .rdata(data_rdata)
  );

  // Update step: second read is on the RAM outputs during this cycle
  always_comb begin
    logic have_free, can_alloc, is_ins;
    idx_t n, d, x;
    have_free = is_node(free_head);
    can_alloc = have_free || (fresh < NULL_IDX);
    n = have_free ? free_head : fresh;
    d = NULL_IDX;
    x = NULL_IDX;
    head_next = head; tail_next = tail; cur_next = cur;
    free_next = free_head; fresh_next = fresh; count_next = live_count;
    status_next = 1'b0;
    w1n_en_next = 1'b0; w1p_en_next = 1'b0; w2n_en_next = 1'b0; w2p_en_next = 1'b0;
    wd_en_next = 1'b0;
    w1n_addr_next = n; w1p_addr_next = n; w2n_addr_next = n; w2p_addr_next = n;
    wd_addr_next = n;
    w1n_data_next = NULL_IDX; w1p_data_next = NULL_IDX;
    w2n_data_next = NULL_IDX; w2p_data_next = NULL_IDX;

    is_ins = (req_q == REQ_INS_FIRST) || (req_q == REQ_INS_LAST) ||
             (((req_q == REQ_INS_AFTER) || (req_q == REQ_INS_BEFORE)) && is_node(cur));
    if (is_ins) begin
      if (!can_alloc) begin
        status_next = 1'b1;
      end else begin
        free_next  = have_free ? next_rdata : free_head;
        fresh_next = have_free ? fresh : fresh + IDX_W'(1);
        count_next = live_count + IDX_W'(1);
        wd_en_next = 1'b1;
      end
    end

    unique case (req_q)
      REQ_CLEAR: begin
        head_next = NULL_IDX; tail_next = NULL_IDX; cur_next = NULL_IDX;
        free_next = NULL_IDX; fresh_next = '0; count_next = '0;
      end
      REQ_INS_FIRST: if (can_alloc) begin
        w1n_en_next = 1'b1; w1n_data_next = head;
        w1p_en_next = 1'b1; w1p_data_next = NULL_IDX;
        w2p_en_next = is_node(head); w2p_addr_next = head; w2p_data_next = n;
        if (!is_node(head)) tail_next = n;
        head_next = n;
      end
      REQ_INS_LAST: if (can_alloc) begin
        w1n_en_next = 1'b1; w1n_data_next = NULL_IDX;
        w1p_en_next = 1'b1; w1p_data_next = tail;
        w2n_en_next = is_node(tail); w2n_addr_next = tail; w2n_data_next = n;
        if (!is_node(tail)) head_next = n;
        tail_next = n;
      end
      REQ_GO_FIRST: cur_next = head;
      REQ_GO_LAST:  cur_next = tail;
      REQ_DEL_FIRST: if (is_node(head)) begin
        d = head; x = r1n;
        if (cur == d) cur_next = NULL_IDX;
        w1p_en_next = is_node(x); w1p_addr_next = x; w1p_data_next = NULL_IDX;
        if (!is_node(x)) tail_next = NULL_IDX;
        head_next = x;
      end
      REQ_DEL_LAST: if (is_node(tail)) begin
        d = tail; x = r1p;
        if (cur == d) cur_next = NULL_IDX;
        w1n_en_next = is_node(x); w1n_addr_next = x; w1n_data_next = NULL_IDX;
        if (!is_node(x)) head_next = NULL_IDX;
        tail_next = x;
      end
      REQ_DEL_AFTER: if (is_node(cur) && (cur != tail) && is_node(r1n)) begin
        d = r1n; x = next_rdata;
        w1n_en_next = 1'b1; w1n_addr_next = cur; w1n_data_next = x;
        w1p_en_next = is_node(x); w1p_addr_next = x; w1p_data_next = cur;
        if (!is_node(x)) tail_next = cur;
      end
      REQ_DEL_BEFORE: if (is_node(cur) && (cur != head) && is_node(r1p)) begin
        d = r1p; x = prev_rdata;
        w1p_en_next = 1'b1; w1p_addr_next = cur; w1p_data_next = x;
        w1n_en_next = is_node(x); w1n_addr_next = x; w1n_data_next = cur;
        if (!is_node(x)) head_next = cur;
      end
      REQ_INS_AFTER: if (is_node(cur) && can_alloc) begin
        x = r1n;
        w1p_en_next = 1'b1; w1p_data_next = cur;
        w1n_en_next = 1'b1; w1n_data_next = x;
        w2p_en_next = is_node(x); w2p_addr_next = x; w2p_data_next = n;
        if (!is_node(x)) tail_next = n;
        w2n_en_next = 1'b1; w2n_addr_next = cur; w2n_data_next = n;
      end
      REQ_INS_BEFORE: if (is_node(cur) && can_alloc) begin
        x = r1p;
        w1n_en_next = 1'b1; w1n_data_next = cur;
        w1p_en_next = 1'b1; w1p_data_next = x;
        w2n_en_next = is_node(x); w2n_addr_next = x; w2n_data_next = n;
        if (!is_node(x)) head_next = n;
        w2p_en_next = 1'b1; w2p_addr_next = cur; w2p_data_next = n;
      end
      REQ_SET_VALUE: if (is_node(cur)) begin
        wd_en_next = 1'b1; wd_addr_next = cur;
      end
      REQ_PREVIOUS: if (is_node(cur)) cur_next = r1p;
      REQ_NEXT:     if (is_node(cur)) cur_next = r1n;
      default: ;
    endcase

    // Return the deleted node to the free list
    if (is_node(d)) begin
      w2n_en_next = 1'b1; w2n_addr_next = d; w2n_data_next = free_head;
      free_next = d;
      if (live_count != '0) count_next = live_count - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= NULL_IDX; tail <= NULL_IDX; cur <= NULL_IDX; free_head <= NULL_IDX;
      fresh <= '0; live_count <= '0;
      w1n_en <= 1'b0; w1p_en <= 1'b0; w2n_en <= 1'b0; w2p_en <= 1'b0; wd_en <= 1'b0;
    end else if (cmd.calc) begin
      head <= head_next; tail <= tail_next; cur <= cur_next;
      free_head <= free_next; fresh <= fresh_next; live_count <= count_next;
      w1n_en <= w1n_en_next; w1p_en <= w1p_en_next;
      w2n_en <= w2n_en_next; w2p_en <= w2p_en_next; wd_en <= wd_en_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_t'(req.req_type);
      val_q <= req.value;
    end
    if (cmd.rd2) begin
      r1n <= next_rdata;
      r1p <= prev_rdata;
    end
    if (cmd.calc) begin
      w1n_addr <= w1n_addr_next; w1n_data <= w1n_data_next;
      w1p_addr <= w1p_addr_next; w1p_data <= w1p_data_next;
      w2n_addr <= w2n_addr_next; w2n_data <= w2n_data_next;
      w2p_addr <= w2p_addr_next; w2p_data <= w2p_data_next;
      wd_addr  <= wd_addr_next;
      rsp.status <= status_next;
    end
    if (cmd.cap_head) begin
      rsp.first_value   <= is_node(head) ? data_rdata : '0;
      rsp.list_empty    <= !is_node(head);
      rsp.active_valid  <= is_node(cur);
      rsp.element_count <= CNT_W'(live_count);
    end
    if (cmd.cap_tail) rsp.last_value   <= is_node(tail) ? data_rdata : '0;
    if (cmd.cap_cur)  rsp.active_value <= is_node(cur) ? data_rdata : '0;
  end

endmodule

// ===== design/doubly_linked_list_with_cursor.sv =====
`timescale 1ns / 1ps
// Doubly linked list of signed 32-bit values in a 64-node pool, with cursor.
// Request channel (req_valid/req_ready/req) carries a request code and value;
// response channel (rsp_valid/rsp_ready/rsp) returns one result per request
// showing the list after the request: end and cursor values, flags, count,
// and a pool-full status on a dropped insert.
// One request is in flight at a time. A response is valid once the request
// has passed the sequencer states RD1, RD2, CALC, WR1, WR2, RDH, RDT, RDC and
// CAPC, and a new request is taken the cycle after the response transaction.
// The sequencer steps are two dependent link reads, one update step, two link
// write slots and three reads of the single value memory port.
// While the receiver stalls, the response holds and no request is taken.
// Reset (rst, synchronous) empties the list and cursor; pool memory contents
// are not cleared, and data read from unwritten locations is never used.
// Depends on dll_pkg, dll_ctrl, dll_dp and dll_ram.
module doubly_linked_list_with_cursor
  import dll_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  dp_cmd_t cmd;

  dll_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd)
  );

  dll_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(req), .rsp(rsp)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while response pending");

  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !rsp_valid)
    else $error("response raised right after request transaction");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.list_empty == (rsp.element_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_no_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.list_empty || !rsp.active_valid))
    else $error("cursor active on empty list");
`endif

endmodule
